@@ rtl/csm_pkg.sv @@
package csm_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ENTRIES = 4096;

    localparam int ROW_W  = 10;   // row index
    localparam int COL_W  = 10;   // column index
    localparam int VAL_W  = 8;    // entry value
    localparam int RC_W   = 11;   // row_count register, row bound
    localparam int CNT_W  = 13;   // entry count, row start pointers
    localparam int RS_AW  = 11;   // row start memory address (MAX_ROWS + 1 entries)
    localparam int ENT_AW = 12;   // entry memory address
    localparam int ENT_W  = COL_W + VAL_W;

    localparam logic [RC_W-1:0] ROW_COUNT_RESET = RC_W'(1024);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DESC  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_STORE,
        S_RD_HI,
        S_SETUP,
        S_PROBE,
        S_CMP,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    clear;
        logic    status_en;
        status_t status;
        logic    fill_append;
        logic    fill_finish;
        logic    fill_step;
        logic    store;
        logic    rd_lo;
        logic    rd_hi;
        logic    setup_range;
        logic    probe;
        logic    compare;
        logic    out_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic row_oob;
        logic row_desc;
        logic row_beyond;
        logic row_adv;
        logic full;
        logic finish_empty;
        logic fill_last;
        logic range_empty;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/csm_ctrl.sv @@
module csm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csm_pkg::dp_stat_t   stat,
    output csm_pkg::ctrl_cmd_t  cmd
);

    csm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = csm_pkg::ST_OK;
        s_ready    = 1'b0;

        case (state_reg)
            csm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = csm_pkg::S_DECODE;
                end
            end

            csm_pkg::S_DECODE: begin
                case (stat.cmd)
                    csm_pkg::CMD_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = csm_pkg::S_RESP;
                    end
                    csm_pkg::CMD_APPEND: begin
                        if (stat.row_oob) begin
                            cmd.status_en = 1'b1;
                            cmd.status    = csm_pkg::ST_RANGE;
                            state_next    = csm_pkg::S_RESP;
                        end else if (stat.row_desc) begin
                            cmd.status_en = 1'b1;
                            cmd.status    = csm_pkg::ST_DESC;
                            state_next    = csm_pkg::S_RESP;
                        end else if (stat.full) begin
                            cmd.status_en = 1'b1;
                            cmd.status    = csm_pkg::ST_FULL;
                            state_next    = csm_pkg::S_RESP;
                        end else if (stat.row_adv) begin
                            cmd.fill_append = 1'b1;
                            state_next      = csm_pkg::S_FILL;
                        end else begin
                            state_next = csm_pkg::S_STORE;
                        end
                    end
                    csm_pkg::CMD_FINISH: begin
                        if (stat.finish_empty) begin
                            state_next = csm_pkg::S_RESP;
                        end else begin
                            cmd.fill_finish = 1'b1;
                            state_next      = csm_pkg::S_FILL;
                        end
                    end
                    csm_pkg::CMD_LOOKUP: begin
                        if (stat.row_oob) begin
                            cmd.status_en = 1'b1;
                            cmd.status    = csm_pkg::ST_RANGE;
                            state_next    = csm_pkg::S_RESP;
                        end else if (stat.row_beyond) begin
                            state_next = csm_pkg::S_RESP;
                        end else begin
                            cmd.rd_lo  = 1'b1;
                            state_next = csm_pkg::S_RD_HI;
                        end
                    end
                    default: begin
                        state_next = csm_pkg::S_RESP;
                    end
                endcase
            end

            csm_pkg::S_FILL: begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last) begin
                    if (stat.cmd == csm_pkg::CMD_APPEND) begin
                        state_next = csm_pkg::S_STORE;
                    end else begin
                        state_next = csm_pkg::S_RESP;
                    end
                end
            end

            csm_pkg::S_STORE: begin
                cmd.store  = 1'b1;
                state_next = csm_pkg::S_RESP;
            end

            csm_pkg::S_RD_HI: begin
                cmd.rd_hi  = 1'b1;
                state_next = csm_pkg::S_SETUP;
            end

            csm_pkg::S_SETUP: begin
                cmd.setup_range = 1'b1;
                state_next      = csm_pkg::S_PROBE;
            end

            csm_pkg::S_PROBE: begin
                if (stat.range_empty) begin
                    state_next = csm_pkg::S_RESP;
                end else begin
                    cmd.probe  = 1'b1;
                    state_next = csm_pkg::S_CMP;
                end
            end

            csm_pkg::S_CMP: begin
                cmd.compare = 1'b1;
                if (stat.hit) begin
                    state_next = csm_pkg::S_RESP;
                end else begin
                    state_next = csm_pkg::S_PROBE;
                end
            end

            csm_pkg::S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = csm_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = csm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/csm_datapath.sv @@
module csm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [csm_pkg::RC_W-1:0]      cfg_wr_data,
    input  logic [1:0]                    s_command,
    input  logic [csm_pkg::ROW_W-1:0]     s_row,
    input  logic [csm_pkg::COL_W-1:0]     s_column,
    input  logic [csm_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csm_pkg::VAL_W-1:0]     m_read_value,
    output logic                          m_found,
    output logic [1:0]                    m_status,
    input  csm_pkg::ctrl_cmd_t            cmd,
    output csm_pkg::dp_stat_t             stat
);

    // request registers
    csm_pkg::cmd_t                   cmd_reg;
    logic [csm_pkg::ROW_W-1:0]       row_reg;
    logic [csm_pkg::COL_W-1:0]       col_reg;
    logic [csm_pkg::VAL_W-1:0]       val_reg;

    logic [csm_pkg::RC_W-1:0]        row_count_reg;
    logic [csm_pkg::CNT_W-1:0]       ec_reg;
    logic [csm_pkg::ROW_W-1:0]       cur_reg;
    logic [csm_pkg::RS_AW-1:0]       fill_ptr_reg;
    logic [csm_pkg::RS_AW-1:0]       fill_last_reg;
    logic [csm_pkg::CNT_W-1:0]       lo_reg;
    logic [csm_pkg::CNT_W-1:0]       hi_reg;
    logic [csm_pkg::CNT_W-1:0]       mid_reg;

    logic [csm_pkg::VAL_W-1:0]       res_value_reg;
    logic                            res_found_reg;
    csm_pkg::status_t                res_status_reg;

    logic                            m_valid_reg;
    logic [csm_pkg::VAL_W-1:0]       m_read_value_reg;
    logic                            m_found_reg;
    csm_pkg::status_t                m_status_reg;

    // row start pointers; entry zero is never written and always reads as zero
    logic [csm_pkg::CNT_W-1:0]       rs_mem [0:csm_pkg::MAX_ROWS];
    logic [csm_pkg::CNT_W-1:0]       rs_rdata_reg;
    logic                            rs_zero_reg;
    logic [csm_pkg::RS_AW-1:0]       rs_raddr;
    logic [csm_pkg::CNT_W-1:0]       rs_q;

    // column and value per entry, column in the upper bits
    logic [csm_pkg::ENT_W-1:0]       ent_mem [0:csm_pkg::MAX_ENTRIES-1];
    logic [csm_pkg::ENT_W-1:0]       ent_rdata_reg;

    logic [csm_pkg::RC_W-1:0]        n_rows;
    logic [csm_pkg::RC_W-1:0]        row_ext;
    logic [csm_pkg::RC_W-1:0]        cur_inc;
    logic [csm_pkg::CNT_W:0]         mid_sum;
    logic [csm_pkg::CNT_W-1:0]       mid;
    logic [csm_pkg::CNT_W-1:0]       hi_raw;
    logic [csm_pkg::CNT_W-1:0]       hi_clip;
    logic [csm_pkg::CNT_W-1:0]       lo_clip;
    logic [csm_pkg::COL_W-1:0]       ent_col;
    logic [csm_pkg::VAL_W-1:0]       ent_val;

    always_comb begin
        if (row_count_reg == '0) begin
            n_rows = csm_pkg::RC_W'(1);
        end else if (row_count_reg > csm_pkg::RC_W'(csm_pkg::MAX_ROWS)) begin
            n_rows = csm_pkg::RC_W'(csm_pkg::MAX_ROWS);
        end else begin
            n_rows = row_count_reg;
        end
    end

    assign row_ext = {1'b0, row_reg};
    assign cur_inc = {1'b0, cur_reg} + csm_pkg::RC_W'(1);

    assign rs_raddr = cmd.rd_lo ? row_ext : row_ext + csm_pkg::RS_AW'(1);
    assign rs_q     = rs_zero_reg ? '0 : rs_rdata_reg;

    assign hi_raw  = (row_reg == cur_reg) ? ec_reg : rs_q;
    assign hi_clip = (hi_raw > ec_reg) ? ec_reg : hi_raw;
    assign lo_clip = (lo_reg > hi_clip) ? hi_clip : lo_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[csm_pkg::CNT_W:1];

    assign ent_col = ent_rdata_reg[csm_pkg::ENT_W-1:csm_pkg::VAL_W];
    assign ent_val = ent_rdata_reg[csm_pkg::VAL_W-1:0];

    always_comb begin
        stat              = '0;
        stat.cmd          = cmd_reg;
        stat.row_oob      = row_ext >= n_rows;
        stat.row_desc     = row_reg < cur_reg;
        stat.row_beyond   = row_reg > cur_reg;
        stat.row_adv      = row_reg != cur_reg;
        stat.full         = ec_reg >= csm_pkg::CNT_W'(csm_pkg::MAX_ENTRIES);
        stat.finish_empty = cur_inc > n_rows;
        stat.fill_last    = fill_ptr_reg == fill_last_reg;
        stat.range_empty  = lo_reg >= hi_reg;
        stat.hit          = ent_col == col_reg;
        stat.out_free     = !m_valid_reg || m_ready;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.fill_step) begin
            rs_mem[fill_ptr_reg] <= ec_reg;
        end
        if (cmd.rd_lo || cmd.rd_hi) begin
            rs_rdata_reg <= rs_mem[rs_raddr];
            rs_zero_reg  <= rs_raddr == '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            ent_mem[ec_reg[csm_pkg::ENT_AW-1:0]] <= {col_reg, val_reg};
        end
        if (cmd.probe) begin
            ent_rdata_reg <= ent_mem[mid[csm_pkg::ENT_AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= csm_pkg::cmd_t'(s_command);
            row_reg <= s_row;
            col_reg <= s_column;
            val_reg <= s_value;
        end
        if (cmd.fill_append) begin
            fill_ptr_reg  <= cur_inc;
            fill_last_reg <= row_ext;
        end else if (cmd.fill_finish) begin
            fill_ptr_reg  <= cur_inc;
            fill_last_reg <= n_rows;
        end else if (cmd.fill_step) begin
            fill_ptr_reg <= fill_ptr_reg + csm_pkg::RS_AW'(1);
        end
        if (cmd.rd_hi) begin
            lo_reg <= rs_q;
        end else if (cmd.setup_range) begin
            lo_reg <= lo_clip;
        end else if (cmd.compare && ent_col < col_reg) begin
            lo_reg <= mid_reg + csm_pkg::CNT_W'(1);
        end
        if (cmd.setup_range) begin
            hi_reg <= hi_clip;
        end else if (cmd.compare && ent_col > col_reg) begin
            hi_reg <= mid_reg;
        end
        if (cmd.probe) begin
            mid_reg <= mid;
        end
        if (cmd.load_in) begin
            res_value_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= csm_pkg::ST_OK;
        end else begin
            if (cmd.status_en) begin
                res_status_reg <= cmd.status;
            end
            if (cmd.compare && ent_col == col_reg) begin
                res_value_reg <= ent_val;
                res_found_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            m_read_value_reg <= res_value_reg;
            m_found_reg      <= res_found_reg;
            m_status_reg     <= res_status_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= csm_pkg::ROW_COUNT_RESET;
            ec_reg        <= '0;
            cur_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                row_count_reg <= cfg_wr_data;
            end
            if (cmd.clear) begin
                ec_reg  <= '0;
                cur_reg <= '0;
            end else if (cmd.store) begin
                ec_reg  <= ec_reg + csm_pkg::CNT_W'(1);
                cur_reg <= row_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_found      = m_found_reg;
    assign m_status     = m_status_reg;

endmodule

@@ rtl/csr_sparse_matrix_store.sv @@
// Each request is decoded; clear and refused requests go straight to the response, append
// fills a row start pointer per row advanced and stores the entry, finish fills one per
// closed row, lookup binary-searches the row (at most 13 probes for 4096 entries). One
// request in flight; the next is taken once the result has loaded, and a result not yet
// taken on m holds the following one in the response state.
// Reset (aresetn, synchronous): entry count, current row, output valid clear, row_count 1024.
module csr_sparse_matrix_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [csm_pkg::RC_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [csm_pkg::ROW_W-1:0]     s_row,
    input  logic [csm_pkg::COL_W-1:0]     s_column,
    input  logic [csm_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [csm_pkg::VAL_W-1:0]     m_read_value,
    output logic                          m_found,
    output logic [1:0]                    m_status
);

    csm_pkg::ctrl_cmd_t cmd;
    csm_pkg::dp_stat_t  stat;

    csm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    csm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_command    (s_command),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_found      (m_found),
        .m_status     (m_status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
